// ===== src/mhic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator package
// Shared widths, axis and register codes, and saturation helper.
// ----------------------------------------------------------------------------
package mhic_pkg;

  localparam int AXIS_W         = 16;
  localparam int GAIN_W         = 16;
  localparam int CNT_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int NUM_AXES       = 3;
  localparam int GAIN_FRAC_BITS = 14;
  localparam int PROD_W         = AXIS_W + GAIN_W + 1;

  localparam logic [CNT_W-1:0] WINDOW_RESET = 16'd300;

  typedef enum logic [1:0] {
    AX_ROLL  = 2'd0,
    AX_PITCH = 2'd1,
    AX_YAW   = 2'd2
  } axis_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_ROLL  = 2'd0,
    CFG_GAIN_PITCH = 2'd1,
    CFG_GAIN_YAW   = 2'd2,
    CFG_WINDOW     = 2'd3
  } cfg_idx_t;

  typedef logic signed [AXIS_W-1:0] axis_val_t;

  // Saturates a signed value of PROD_W bits to the signed axis range.
  function automatic axis_val_t sat_axis(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'(32767);
    lo = -PROD_W'(32768);
    if (v > hi) begin
      sat_axis = 16'sh7FFF;
    end else if (v < lo) begin
      sat_axis = 16'sh8000;
    end else begin
      sat_axis = v[AXIS_W-1:0];
    end
  endfunction

endpackage

// ===== src/mhic_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer sample channel
// Valid/ready channel carrying one raw three-axis sample per transaction.
// ----------------------------------------------------------------------------
interface mhic_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_z;
  logic signed [15:0] raw_y;
  logic               restart_cal;

  modport source (output valid, raw_x, raw_z, raw_y, restart_cal, input ready);
  modport sink (input valid, raw_x, raw_z, raw_y, restart_cal, output ready);
endinterface

// ===== src/mhic_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer result channel
// Valid/ready channel carrying one calibrated field vector per transaction.
// ----------------------------------------------------------------------------
interface mhic_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mag_roll;
  logic signed [15:0] mag_pitch;
  logic signed [15:0] mag_yaw;
  logic               uncorrected;

  modport source (output valid, mag_roll, mag_pitch, mag_yaw, uncorrected, input ready);
  modport sink (input valid, mag_roll, mag_pitch, mag_yaw, uncorrected, output ready);
endinterface

// ===== src/mhic_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer calibrator configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface mhic_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/magnetometer_hard_iron_calibrator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer hard-iron calibrator
// Scales three magnetometer axes, finds the hard-iron zero from the min/max
// over a calibration window and subtracts it afterwards.
//
// The in_chan channel takes one raw sample (X, Z, Y words and a restart
// flag) per transaction; the out_chan channel returns one result per sample,
// in order. The cfg_chan channel writes the three axis gains and the window
// length and is always ready. The user must write only while no sample is
// in flight; the block does not enforce this. The two register stages are an
// input register and the result register, with the three gain multipliers,
// the min/max tracking and the zero subtraction between them. One sample is
// taken every cycle until the receiver stalls, and passes both registers to
// reach out_chan.valid. On a stall the result register holds while the input
// register still fills: up to two samples are buffered before in_chan.ready
// drops. Reset empties the pipeline, loads default gains of 1.0 and a
// window of 300 samples, clears the zeros and starts calibration.
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibrator_unit import mhic_pkg::*; #(
  parameter int GAIN_FRAC = GAIN_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  mhic_in_if.sink    in_chan,
  mhic_out_if.source out_chan,
  mhic_cfg_if.sink   cfg_chan
);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(64'd1 << GAIN_FRAC);

  logic [GAIN_W-1:0] gain_r [NUM_AXES];
  logic [CNT_W-1:0]  window_r;

  logic              s1_valid_r;
  axis_val_t         s1_raw_r [NUM_AXES];
  logic              s1_restart_r;

  logic              out_valid_r;
  axis_val_t         out_val_r [NUM_AXES];
  logic              out_uncorr_r;

  axis_val_t         min_r [NUM_AXES];
  axis_val_t         max_r [NUM_AXES];
  axis_val_t         zero_r [NUM_AXES];
  logic              cal_r;
  logic [CNT_W-1:0]  cnt_r;

  axis_val_t         min_nxt [NUM_AXES];
  axis_val_t         max_nxt [NUM_AXES];
  axis_val_t         zero_nxt [NUM_AXES];
  axis_val_t         res_nxt [NUM_AXES];
  logic              cal_nxt;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              uncorr_nxt;

  axis_val_t         scaled [NUM_AXES];
  logic              out_adv;
  logic              s1_adv;
  logic              s1_fire;

  assign out_adv = !out_valid_r || out_chan.ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign s1_fire = s1_valid_r && out_adv;

  assign in_chan.ready  = s1_adv;
  assign cfg_chan.ready = 1'b1;

  genvar g;
  generate
    for (g = 0; g < NUM_AXES; g++) begin : g_scale
      mhic_axis_scale #(
        .FRAC_BITS (GAIN_FRAC)
      ) u_scale (
        .raw    (s1_raw_r[g]),
        .gain   (gain_r[g]),
        .scaled (scaled[g])
      );
    end
  endgenerate

  always_comb begin
    logic              cal_eff;
    logic [CNT_W-1:0]  cnt_eff;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  win;
    logic              done;
    logic signed [AXIS_W:0] sum;
    logic signed [PROD_W-1:0] diff;

    cal_eff = s1_restart_r || cal_r;
    cnt_eff = s1_restart_r ? '0 : cnt_r;
    cnt_inc = cnt_eff + CNT_W'(1);
    win     = (window_r == '0) ? CNT_W'(1) : window_r;
    done    = cal_eff && (cnt_inc >= win);

    uncorr_nxt = cal_eff;
    cal_nxt    = cal_eff && !done;
    cnt_nxt    = (cal_eff && !done) ? cnt_inc : '0;

    for (int i = 0; i < NUM_AXES; i++) begin
      min_nxt[i]  = min_r[i];
      max_nxt[i]  = max_r[i];
      zero_nxt[i] = zero_r[i];
      if (cal_eff) begin
        if (cnt_eff == '0 || scaled[i] < min_r[i]) begin
          min_nxt[i] = scaled[i];
        end
        if (cnt_eff == '0 || scaled[i] > max_r[i]) begin
          max_nxt[i] = scaled[i];
        end
      end
      sum = (AXIS_W+1)'(min_nxt[i]) + (AXIS_W+1)'(max_nxt[i]);
      if (done) begin
        zero_nxt[i] = sum[AXIS_W:1];
      end
      diff = PROD_W'(scaled[i]) - PROD_W'(zero_r[i]);
      res_nxt[i] = cal_eff ? scaled[i] : sat_axis(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cal_r       <= 1'b1;
      cnt_r       <= '0;
      window_r    <= WINDOW_RESET;
      for (int i = 0; i < NUM_AXES; i++) begin
        gain_r[i] <= GAIN_ONE;
        min_r[i]  <= '0;
        max_r[i]  <= '0;
        zero_r[i] <= '0;
      end
    end else begin
      if (s1_adv) begin
        s1_valid_r <= in_chan.valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_fire) begin
        cal_r <= cal_nxt;
        cnt_r <= cnt_nxt;
        for (int i = 0; i < NUM_AXES; i++) begin
          min_r[i]  <= min_nxt[i];
          max_r[i]  <= max_nxt[i];
          zero_r[i] <= zero_nxt[i];
        end
      end
      if (cfg_chan.valid) begin
        unique case (cfg_idx_t'(cfg_chan.index))
          CFG_GAIN_ROLL:  gain_r[AX_ROLL]  <= cfg_chan.data;
          CFG_GAIN_PITCH: gain_r[AX_PITCH] <= cfg_chan.data;
          CFG_GAIN_YAW:   gain_r[AX_YAW]   <= cfg_chan.data;
          CFG_WINDOW:     window_r         <= cfg_chan.data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_chan.valid) begin
      s1_raw_r[AX_ROLL]  <= in_chan.raw_x;
      s1_raw_r[AX_YAW]   <= in_chan.raw_z;
      s1_raw_r[AX_PITCH] <= in_chan.raw_y;
      s1_restart_r       <= in_chan.restart_cal;
    end
    if (s1_fire) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        out_val_r[i] <= res_nxt[i];
      end
      out_uncorr_r <= uncorr_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.mag_roll    = out_val_r[AX_ROLL];
  assign out_chan.mag_pitch   = out_val_r[AX_PITCH];
  assign out_chan.mag_yaw     = out_val_r[AX_YAW];
  assign out_chan.uncorrected = out_uncorr_r;

endmodule

// ===== src/mhic_axis_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Magnetometer axis scaler
// Multiplies a raw axis word by an unsigned fixed-point gain, truncates
// toward zero and saturates to the signed axis range.
// ----------------------------------------------------------------------------
module mhic_axis_scale import mhic_pkg::*; #(
  parameter int FRAC_BITS = GAIN_FRAC_BITS
) (
  input  logic signed [AXIS_W-1:0] raw,
  input  logic [GAIN_W-1:0]        gain,
  output axis_val_t                scaled
);

  localparam logic signed [PROD_W-1:0] BIAS =
    PROD_W'((64'd1 << FRAC_BITS) - 64'd1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] adj;
  logic signed [PROD_W-1:0] shifted;

  // Adding the bias to negative products makes the arithmetic shift
  // round toward zero.
  assign prod    = PROD_W'(raw) * PROD_W'($signed({1'b0, gain}));
  assign adj     = prod[PROD_W-1] ? (prod + BIAS) : prod;
  assign shifted = adj >>> FRAC_BITS;
  assign scaled  = sat_axis(shifted);

endmodule
